// File: hdl/ttc_pkg.sv
package ttc_pkg;

  localparam int MAX_COLUMNS     = 256;
  localparam int MAX_ROWS_STORED = 128;
  localparam int COL_W           = 8;
  localparam int ROW_W           = 7;
  localparam int ADDR_W          = COL_W + ROW_W;
  localparam int STORE_DEPTH     = MAX_COLUMNS * MAX_ROWS_STORED;
  localparam int CELL_W          = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  localparam logic [8:0] COLS_RESET = 9'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;

  // Register select is address bit 2 (registers at byte 0 and 4).
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [3:0] MODE_PUT      = 4'd0;
  localparam logic [3:0] MODE_BKSP     = 4'd1;
  localparam logic [3:0] MODE_LEFT     = 4'd2;
  localparam logic [3:0] MODE_RIGHT    = 4'd3;
  localparam logic [3:0] MODE_CLEAR    = 4'd4;
  localparam logic [3:0] MODE_CLRLINE  = 4'd5;
  localparam logic [3:0] MODE_PUTAT    = 4'd6;
  localparam logic [3:0] MODE_SETCUR   = 4'd7;
  localparam logic [3:0] MODE_SHOW     = 4'd8;
  localparam logic [3:0] MODE_HIDE     = 4'd9;
  localparam logic [3:0] MODE_BLINK    = 4'd10;
  localparam logic [3:0] MODE_READ     = 4'd11;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_CLEAR,
    ST_CLRLINE,
    ST_RDWAIT,
    ST_DONE
  } ttc_state_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [7:0] target_column;
    logic [6:0] target_row;
  } ttc_in_t;

  typedef struct packed {
    logic [7:0] cursor_column;
    logic [6:0] cursor_line;
    logic       cursor_lit;
    logic       did_scroll;
    logic [7:0] read_character;
    logic [7:0] read_attribute;
  } ttc_out_t;

endpackage

// File: hdl/ttc_ram.sv
module ttc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/text_terminal_cell_controller.sv
// Text terminal cell controller. Commands arrive one beat at a time on the in_ channel and
// each produces exactly one result beat on the out_ channel. A new command is taken only when
// idle or once the result of the last one can be sent. Commands that walk the cell memory
// are bound by its single write port: a clear writes all rows*columns cells, a clear line
// writes the remaining columns of the cursor row, and a put or newline that scrolls copies
// rows 1 to rows-1 up by one row and then blanks the bottom row.
// After reset the block sweeps all 32768 cells to space with attribute 0x07, one cell per
// cycle, and holds in_stall high until the sweep is done; configuration writes are taken
// throughout.
module text_terminal_cell_controller
  import ttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ttc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ttc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ttc_state_t state_r, state_nxt;
  ttc_in_t    cmd_r, cmd_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [6:0] wr_r, wr_nxt;
  logic       shown_r, shown_nxt;
  logic       blink_r, blink_nxt;
  logic [8:0] cols_cfg_r;
  logic [7:0] rows_cfg_r;
  logic [7:0] x_r, x_nxt;
  logic [6:0] y_r, y_nxt;
  logic       scr_r, scr_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic        cp_v_r;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic [ADDR_W-1:0] init_r;
  logic        out_valid_r;
  ttc_out_t    out_data_r;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [8:0] cols;
  logic [7:0] rows;
  logic [7:0] last_col;
  logic [6:0] last_row;
  logic       x_last, y_last, init_last;
  logic       out_free, accept;
  logic       pos_active, tgt_active, need_nl, nl_scroll;
  logic [8:0] wc_inc;
  logic [7:0] wr_inc;
  logic [7:0] bs_col;
  logic [6:0] bs_row;
  logic       bs_moves;

  ttc_ram #(.WIDTH(CELL_W), .DEPTH(STORE_DEPTH)) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (cols_cfg_r == 9'd0) begin
      cols = 9'd1;
    end else if (cols_cfg_r > 9'(MAX_COLUMNS)) begin
      cols = 9'(MAX_COLUMNS);
    end else begin
      cols = cols_cfg_r;
    end
    if (rows_cfg_r == 8'd0) begin
      rows = 8'd1;
    end else if (rows_cfg_r > 8'(MAX_ROWS_STORED)) begin
      rows = 8'(MAX_ROWS_STORED);
    end else begin
      rows = rows_cfg_r;
    end
  end

  assign last_col  = 8'(cols - 9'd1);
  assign last_row  = 7'(rows - 8'd1);
  assign x_last    = (x_r == last_col);
  assign y_last    = (y_r == last_row);
  assign init_last = (init_r == {ADDR_W{1'b1}});

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_DONE) && out_free));
  assign accept   = in_valid && !in_stall;

  assign pos_active = ({1'b0, wc_r} < cols) && ({1'b0, wr_r} < rows);
  assign tgt_active = ({1'b0, cmd_r.target_column} < cols) &&
                      ({1'b0, cmd_r.target_row} < rows);
  assign wc_inc     = {1'b0, wc_r} + 9'd1;
  assign wr_inc     = {1'b0, wr_r} + 8'd1;
  assign need_nl    = (cmd_r.character == NEWLINE_CODE) || (wc_inc >= cols);
  assign nl_scroll  = need_nl && (wr_inc >= rows);

  // Backspace target position; at the top left nothing moves.
  assign bs_moves = (wc_r != 8'd0) || (wr_r != 7'd0);
  assign bs_col   = (wc_r == 8'd0) ? last_col : wc_r - 8'd1;
  assign bs_row   = (wc_r == 8'd0) ? wr_r - 7'd1 : wr_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (cmd_r.mode)
          MODE_PUT: begin
            if (nl_scroll) state_nxt = (rows > 8'd1) ? ST_SCROLL : ST_FILL;
          end
          MODE_CLEAR:   state_nxt = ST_CLEAR;
          MODE_CLRLINE: begin
            if (pos_active) state_nxt = ST_CLRLINE;
          end
          MODE_READ: begin
            if (tgt_active) state_nxt = ST_RDWAIT;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        if (x_last && y_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:   state_nxt = ST_FILL;
      ST_FILL: begin
        if (x_last) state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        if (x_last && y_last) state_nxt = ST_DONE;
      end
      ST_CLRLINE: begin
        if (x_last) state_nxt = ST_DONE;
      end
      ST_RDWAIT:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_nxt     = cmd_r;
    wc_nxt      = wc_r;
    wr_nxt      = wr_r;
    shown_nxt   = shown_r;
    blink_nxt   = blink_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    scr_nxt     = scr_r;
    rd_nxt      = rd_r;
    cp_addr_nxt = cp_addr_r;
    ram_we      = 1'b0;
    ram_waddr   = {wr_r, wc_r};
    ram_wdata   = {SPACE_CODE, cmd_r.attribute};
    ram_re      = 1'b0;
    ram_raddr   = {y_r, x_r};

    if (accept) begin
      cmd_nxt = in_data;
      scr_nxt = 1'b0;
      rd_nxt  = '0;
    end

    // A copy read issued last cycle lands in the row above.
    if (cp_v_r) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr_r;
      ram_wdata = ram_rdata;
    end

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_r;
        ram_wdata = {SPACE_CODE, RESET_ATTR};
      end
      ST_EXEC: begin
        case (cmd_r.mode)
          MODE_PUT: begin
            if (cmd_r.character != NEWLINE_CODE) begin
              ram_we    = pos_active;
              ram_wdata = {cmd_r.character, cmd_r.attribute};
              wc_nxt    = wc_inc[7:0];
            end
            if (need_nl) begin
              wc_nxt = 8'd0;
              if (nl_scroll) begin
                scr_nxt = 1'b1;
                wr_nxt  = last_row;
                x_nxt   = 8'd0;
                y_nxt   = 7'd1;
              end else begin
                wr_nxt = wr_inc[6:0];
              end
            end
            if (shown_r) blink_nxt = 1'b1;
          end
          MODE_BKSP: begin
            if (bs_moves) begin
              wc_nxt    = bs_col;
              wr_nxt    = bs_row;
              ram_waddr = {bs_row, bs_col};
              ram_we    = ({1'b0, bs_col} < cols) && ({1'b0, bs_row} < rows);
              if (shown_r) blink_nxt = 1'b1;
            end
          end
          MODE_LEFT: begin
            if (wc_r != 8'd0) begin
              wc_nxt = wc_r - 8'd1;
              if (shown_r) blink_nxt = 1'b1;
            end
          end
          MODE_RIGHT: begin
            if (wc_inc < cols) begin
              wc_nxt = wc_inc[7:0];
              if (shown_r) blink_nxt = 1'b1;
            end
          end
          MODE_CLEAR: begin
            x_nxt  = 8'd0;
            y_nxt  = 7'd0;
            wc_nxt = 8'd0;
            wr_nxt = 7'd0;
            if (shown_r) blink_nxt = 1'b1;
          end
          MODE_CLRLINE: begin
            x_nxt = wc_r;
          end
          MODE_PUTAT: begin
            ram_we    = tgt_active;
            ram_waddr = {cmd_r.target_row, cmd_r.target_column};
            ram_wdata = {cmd_r.character, cmd_r.attribute};
          end
          MODE_SETCUR: begin
            wc_nxt = ({1'b0, cmd_r.target_column} >= cols) ? last_col : cmd_r.target_column;
            wr_nxt = ({1'b0, cmd_r.target_row} >= rows) ? last_row : cmd_r.target_row;
            if (shown_r) blink_nxt = 1'b1;
          end
          MODE_SHOW: begin
            shown_nxt = 1'b1;
            blink_nxt = 1'b1;
          end
          MODE_HIDE: begin
            shown_nxt = 1'b0;
          end
          MODE_BLINK: begin
            if (shown_r) blink_nxt = !blink_r;
          end
          MODE_READ: begin
            ram_re    = tgt_active;
            ram_raddr = {cmd_r.target_row, cmd_r.target_column};
          end
          default: begin
          end
        endcase
      end
      ST_SCROLL: begin
        ram_re      = 1'b1;
        cp_addr_nxt = {y_r - 7'd1, x_r};
        if (x_last) begin
          x_nxt = 8'd0;
          y_nxt = y_r + 7'd1;
        end else begin
          x_nxt = x_r + 8'd1;
        end
      end
      ST_DRAIN: begin
        x_nxt = 8'd0;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = {last_row, x_r};
        x_nxt     = x_r + 8'd1;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {y_r, x_r};
        if (x_last) begin
          x_nxt = 8'd0;
          y_nxt = y_r + 7'd1;
        end else begin
          x_nxt = x_r + 8'd1;
        end
      end
      ST_CLRLINE: begin
        ram_we    = 1'b1;
        ram_waddr = {wr_r, x_r};
        x_nxt     = x_r + 8'd1;
      end
      ST_RDWAIT: begin
        rd_nxt = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      wc_r        <= 8'd0;
      wr_r        <= 7'd0;
      shown_r     <= 1'b0;
      blink_r     <= 1'b1;
      cols_cfg_r  <= COLS_RESET;
      rows_cfg_r  <= ROWS_RESET;
      cp_v_r      <= 1'b0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r    <= wc_nxt;
      wr_r    <= wr_nxt;
      shown_r <= shown_nxt;
      blink_r <= blink_nxt;
      cp_v_r  <= (state_r == ST_SCROLL);
      if (state_r == ST_INIT) init_r <= init_r + ADDR_W'(1);
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_COLUMNS) begin
          cols_cfg_r <= pwdata[8:0];
        end else begin
          rows_cfg_r <= pwdata[7:0];
        end
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    scr_r     <= scr_nxt;
    rd_r      <= rd_nxt;
    cp_addr_r <= cp_addr_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r.cursor_column  <= wc_r;
      out_data_r.cursor_line    <= wr_r;
      out_data_r.cursor_lit     <= shown_r && blink_r;
      out_data_r.did_scroll     <= scr_r;
      out_data_r.read_character <= rd_r[15:8];
      out_data_r.read_attribute <= rd_r[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_ROWS) ? {24'd0, rows_cfg_r} : {23'd0, cols_cfg_r};

endmodule

// File: hdl/ttc_checker.sv
module ttc_checker
  import ttc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ttc_out_t out_data
);

  // The store is swept after reset, so no command can be taken right after it.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // Every command passes through its execute state before the next beat is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("two input beats in consecutive cycles");

  // A scroll always comes from a new line, which leaves the column at zero.
  a_scroll_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.did_scroll |-> out_data.cursor_column == 8'd0)
    else $error("scroll reported with nonzero column");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind text_terminal_cell_controller ttc_checker u_ttc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
